// ===== hdl/xsegtree_pkg.sv =====
// Shared types and constants for the XOR segment tree range query block.
// Used by the top level; has no dependencies of its own.
package xsegtree_pkg;

	// Fixed field widths of the stream items.
	localparam int unsigned POS_W      = 10;
	localparam int unsigned MASK_IN_W  = 26;
	localparam int unsigned OUT_W      = 26;
	localparam int unsigned S_TDATA_W  = 48;
	localparam int unsigned M_TDATA_W  = 32;

	// Default sizing of the tree.
	localparam int unsigned LEAF_COUNT_DEF = 1024;
	localparam int unsigned MASK_BITS_DEF  = 26;

	// Command codes carried in s_tuser.
	localparam logic CMD_TOGGLE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEAF,
		ST_UP,
		ST_QUERY,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/xsegtree_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stand-alone; no package needed.
module xsegtree_ram #(
	parameter int unsigned WIDTH = 26,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/xor_segment_tree_range_query.sv =====
// XOR segment tree over LEAF_COUNT leaves of MASK_BITS bits, held in one RAM of
// 2*LEAF_COUNT nodes (leaf p at node LEAF_COUNT+p). Uses xsegtree_pkg and xsegtree_ram.
//
// After reset the block runs a clearing pass over all 2*LEAF_COUNT nodes, one node per
// cycle, with s_tready low. Then it takes one item at a time. A toggle (s_tuser = 0)
// reads the leaf, writes it back with the mask applied, and climbs to the root with
// one sibling read and one parent write per level. A range query walks both range
// borders up the tree; at each level it reads the left border node if needed, then
// the right border node if needed, each through the single read port, then moves
// both borders up. A range rejected outright goes straight to the result. The result
// register lets the next item be accepted while a result waits on m_tready.
// Toggles return 0; an empty, reversed or out-of-range query returns 0, and a range
// end past the last leaf is clamped to it. Toggles of a position past the last leaf
// change nothing.
module xor_segment_tree_range_query #(
	parameter int unsigned LEAF_COUNT = xsegtree_pkg::LEAF_COUNT_DEF,
	parameter int unsigned MASK_BITS  = xsegtree_pkg::MASK_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// left_pos [9:0], right_pos [19:10], toggle_mask [45:20], zero pad [47:46]
	input  logic [xsegtree_pkg::S_TDATA_W-1:0] s_tdata,
	// command [0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// range_xor [25:0], zero pad [31:26]
	output logic [xsegtree_pkg::M_TDATA_W-1:0] m_tdata
);

	import xsegtree_pkg::*;

	localparam int unsigned DEPTH = 2 * LEAF_COUNT;
	localparam int unsigned NW    = $clog2(DEPTH);
	localparam int unsigned CW    = NW + 1;
	localparam int unsigned PW    = (CW > POS_W) ? CW : POS_W;
	localparam int unsigned WW    = (MASK_BITS > MASK_IN_W) ? MASK_BITS : MASK_IN_W;
	localparam int unsigned OW    = (MASK_BITS > OUT_W) ? MASK_BITS : OUT_W;

	localparam logic [PW-1:0] LEAF_P    = PW'(LEAF_COUNT);
	localparam logic [PW-1:0] LAST_P    = PW'(LEAF_COUNT - 1);
	localparam logic [CW-1:0] LEAF_C    = CW'(LEAF_COUNT);
	localparam logic [CW-1:0] LAST_NODE = CW'(DEPTH - 1);
	localparam logic [CW-1:0] ONE_C     = CW'(1);

	state_t state_q, state_d;

	logic [CW-1:0]        idx_q, idx_d;
	logic [CW-1:0]        lo_q, lo_d;
	logic [CW-1:0]        hi_q, hi_d;
	logic [CW-1:0]        clr_q, clr_d;
	logic [MASK_BITS-1:0] cur_q, cur_d;
	logic [MASK_BITS-1:0] mask_q, mask_d;
	logic [MASK_BITS-1:0] acc_q, acc_d;
	logic                 pend_q, pend_d;
	logic [OUT_W-1:0]     res_q, res_d;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;
	logic                 out_load;

	logic                 ram_we;
	logic [NW-1:0]        ram_waddr;
	logic [MASK_BITS-1:0] ram_wdata;
	logic [NW-1:0]        ram_raddr;
	logic [MASK_BITS-1:0] ram_rdata;

	logic [PW-1:0]        left_p;
	logic [PW-1:0]        right_p;
	logic [PW-1:0]        right_c;
	logic [WW-1:0]        mask_ext;
	logic [MASK_BITS-1:0] mask_in;
	logic [CW-1:0]        leaf_idx;
	logic [CW-1:0]        parent;
	logic [CW-1:0]        hi_dec;
	logic [MASK_BITS-1:0] node_val;
	logic [MASK_BITS-1:0] acc_n;
	logic [OW-1:0]        acc_ext;

	xsegtree_ram #(
		.WIDTH(MASK_BITS),
		.DEPTH(DEPTH)
	) u_nodes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign left_p   = PW'(s_tdata[POS_W-1:0]);
	assign right_p  = PW'(s_tdata[2*POS_W-1:POS_W]);
	assign right_c  = (right_p >= LEAF_P) ? LAST_P : right_p;
	assign mask_ext = WW'(s_tdata[2*POS_W+MASK_IN_W-1:2*POS_W]);
	assign mask_in  = mask_ext[MASK_BITS-1:0];
	assign leaf_idx = left_p[CW-1:0] + LEAF_C;
	assign parent   = idx_q >> 1;
	assign hi_dec   = hi_q - ONE_C;
	assign node_val = cur_q ^ ram_rdata;
	// A read issued in the previous query step lands in the accumulator now.
	assign acc_n    = pend_q ? (acc_q ^ ram_rdata) : acc_q;
	assign acc_ext  = OW'(acc_n);

	assign s_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_data_q);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		clr_d     = clr_q;
		cur_d     = cur_q;
		mask_d    = mask_q;
		acc_d     = acc_q;
		pend_d    = pend_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[NW-1:0];
		ram_wdata = node_val;
		ram_raddr = idx_q[NW-1:0];

		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q[NW-1:0];
				ram_wdata = '0;
				clr_d     = clr_q + ONE_C;
				if (clr_q == LAST_NODE) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					res_d = '0;
					if (s_tuser == CMD_TOGGLE) begin
						if (left_p >= LEAF_P) begin
							state_d = ST_DONE;
						end else begin
							idx_d     = leaf_idx;
							mask_d    = mask_in;
							ram_raddr = leaf_idx[NW-1:0];
							state_d   = ST_LEAF;
						end
					end else begin
						if (left_p > right_p || left_p >= LEAF_P) begin
							state_d = ST_DONE;
						end else begin
							lo_d    = leaf_idx;
							hi_d    = right_c[CW-1:0] + LEAF_C + ONE_C;
							acc_d   = '0;
							pend_d  = 1'b0;
							state_d = ST_QUERY;
						end
					end
				end
			end
			ST_LEAF: begin
				// Write the toggled leaf and fetch its sibling in the same cycle.
				ram_we    = 1'b1;
				ram_wdata = ram_rdata ^ mask_q;
				cur_d     = ram_rdata ^ mask_q;
				ram_raddr = {idx_q[NW-1:1], ~idx_q[0]};
				state_d   = ST_UP;
			end
			ST_UP: begin
				ram_we    = 1'b1;
				ram_waddr = parent[NW-1:0];
				ram_wdata = node_val;
				ram_raddr = {parent[NW-1:1], ~parent[0]};
				idx_d     = parent;
				cur_d     = node_val;
				if (parent == ONE_C) begin
					state_d = ST_DONE;
				end
			end
			ST_QUERY: begin
				acc_d  = acc_n;
				pend_d = 1'b0;
				if (lo_q < hi_q) begin
					if (lo_q[0]) begin
						ram_raddr = lo_q[NW-1:0];
						pend_d    = 1'b1;
						lo_d      = lo_q + ONE_C;
					end else if (hi_q[0]) begin
						ram_raddr = hi_dec[NW-1:0];
						pend_d    = 1'b1;
						hi_d      = hi_dec;
					end else begin
						lo_d = lo_q >> 1;
						hi_d = hi_q >> 1;
					end
				end else begin
					res_d   = acc_ext[OUT_W-1:0];
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			pend_q  <= pend_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		cur_q  <= cur_d;
		mask_q <= mask_d;
		acc_q  <= acc_d;
		res_q  <= res_d;
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

endmodule

// ===== verif/tb_xor_segment_tree_range_query.sv =====
// Self-checking testbench for the XOR segment tree range query block.
// Depends on xsegtree_pkg and on the RTL of xor_segment_tree_range_query; needs no files.
// Items are checked against a local tree model under random idling and back-pressure.
module tb_xor_segment_tree_range_query;
	timeunit 1ns;
	timeprecision 1ps;

	import xsegtree_pkg::*;

	localparam int unsigned LEAVES      = LEAF_COUNT_DEF;
	localparam int unsigned MBITS       = MASK_BITS_DEF;
	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int unsigned DRAIN_WAIT  = 60;
	localparam int unsigned MAX_REPORTS = 10;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = CMD_TOGGLE;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Local copy of the tree and the results still owed by the block.
	logic [MBITS-1:0] tree_model [2*LEAVES];
	logic [OUT_W-1:0] range_xor_q [$];

	int unsigned errors      = 0;
	int unsigned n_toggles   = 0;
	int unsigned n_queries   = 0;
	int unsigned n_results   = 0;
	int unsigned n_nonzero   = 0;
	int unsigned max_in_wait = 0;
	int unsigned rx_hold_len = 0;
	bit          tx_gaps     = 1'b1;
	bit          rx_stalls   = 1'b1;

	xor_segment_tree_range_query i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(0, 3);
	endfunction

	// Appends one result to the list of those the block still owes.
	function automatic void queue_result(logic [OUT_W-1:0] value);
		range_xor_q.insert(range_xor_q.size(), value);
	endfunction

	function automatic void toggle_leaf(int unsigned pos, logic [MASK_IN_W-1:0] mask);
		int unsigned node;
		if (pos >= LEAVES)
			return;
		node = pos + LEAVES;
		tree_model[node] = tree_model[node] ^ mask[MBITS-1:0];
		while (node > 1) begin
			node = node >> 1;
			tree_model[node] = tree_model[2*node] ^ tree_model[2*node+1];
		end
	endfunction

	// Bottom-up walk of both range borders over the half-open span [lo, hi).
	function automatic logic [OUT_W-1:0] range_xor_of(int unsigned lpos, int unsigned rpos);
		logic [MBITS-1:0] acc;
		int unsigned      lo;
		int unsigned      hi;
		acc = '0;
		if (lpos > rpos || lpos >= LEAVES)
			return '0;
		if (rpos >= LEAVES)
			rpos = LEAVES - 1;
		lo = lpos + LEAVES;
		hi = rpos + LEAVES + 1;
		while (lo < hi) begin
			if (lo[0]) begin
				acc = acc ^ tree_model[lo];
				lo++;
			end
			if (hi[0]) begin
				hi--;
				acc = acc ^ tree_model[hi];
			end
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return OUT_W'(acc);
	endfunction

	// Offers one item and records its expected result once the block takes it.
	// Must be entered right after a rising edge; leaves s_tvalid high on return.
	task automatic send_item(input logic cmd, input logic [POS_W-1:0] lpos,
			input logic [POS_W-1:0] rpos, input logic [MASK_IN_W-1:0] mask);
		int unsigned gap;
		int unsigned waited;
		gap = tx_gaps ? gap_len() : 0;
		waited = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, mask, rpos, lpos};
		do begin
			@(posedge clk);
			waited++;
		end while (!s_tready);
		if (waited > max_in_wait)
			max_in_wait = waited;
		if (cmd == CMD_TOGGLE) begin
			toggle_leaf(lpos, mask);
			queue_result('0);
			n_toggles++;
		end else begin
			queue_result(range_xor_of(lpos, rpos));
			n_queries++;
		end
	endtask

	// Stops offering items and waits until every owed result has come back.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (range_xor_q.size() != 0)
			@(posedge clk);
	endtask

	// Mix of range shapes; plain random pairs come out reversed about half the time.
	task automatic pick_range(output logic [POS_W-1:0] lpos, output logic [POS_W-1:0] rpos);
		logic [POS_W-1:0] a;
		logic [POS_W-1:0] b;
		a = POS_W'($urandom());
		b = POS_W'($urandom());
		case ($urandom_range(0, 5))
			0: begin
				lpos = a;
				rpos = b;
			end
			1, 2: begin
				lpos = (a < b) ? a : b;
				rpos = (a < b) ? b : a;
			end
			3: begin
				lpos = a;
				rpos = (a > LEAVES - 1 - 8) ? POS_W'(LEAVES - 1)
					: POS_W'(a + $urandom_range(0, 8));
			end
			4: begin
				lpos = a;
				rpos = a;
			end
			default: begin
				lpos = a[0] ? '0 : a;
				rpos = a[0] ? b : POS_W'(LEAVES - 1);
			end
		endcase
	endtask

	task automatic test_directed();
		send_item(CMD_QUERY, '0, POS_W'(LEAVES - 1), '0);
		send_item(CMD_TOGGLE, '0, '0, '1);
		send_item(CMD_TOGGLE, POS_W'(LEAVES - 1), '1, '1);
		send_item(CMD_QUERY, '0, '0, '0);
		send_item(CMD_QUERY, POS_W'(LEAVES - 1), POS_W'(LEAVES - 1), '0);
		send_item(CMD_QUERY, '0, POS_W'(LEAVES - 1), '1);
		send_item(CMD_TOGGLE, 10'd511, 10'd3, 26'h2AAAAAA);
		send_item(CMD_TOGGLE, 10'd512, 10'd1000, 26'h1555555);
		send_item(CMD_QUERY, 10'd511, 10'd512, '0);
		send_item(CMD_QUERY, 10'd1, POS_W'(LEAVES - 1), '0);
		send_item(CMD_QUERY, '0, POS_W'(LEAVES - 2), '0);
		// Reversed ranges return zero, including the widest one.
		send_item(CMD_QUERY, 10'd5, 10'd3, '0);
		send_item(CMD_QUERY, POS_W'(LEAVES - 1), '0, '0);
		send_item(CMD_QUERY, 10'd512, 10'd511, '0);
		// A zero mask changes nothing; a mask that is the XOR of the two before it cancels them out.
		send_item(CMD_TOGGLE, 10'd300, '0, '0);
		send_item(CMD_TOGGLE, 10'd300, '0, 26'h0000001);
		send_item(CMD_TOGGLE, 10'd300, '0, 26'h2000000);
		send_item(CMD_QUERY, 10'd299, 10'd301, '0);
		send_item(CMD_TOGGLE, 10'd300, '0, 26'h2000001);
		send_item(CMD_QUERY, 10'd299, 10'd301, '0);
		send_item(CMD_TOGGLE, '0, '0, '1);
		send_item(CMD_QUERY, '0, POS_W'(LEAVES - 1), '0);
		wait_drain();
	endtask

	task automatic test_random_mix(input int unsigned count);
		logic [POS_W-1:0]     lpos;
		logic [POS_W-1:0]     rpos;
		logic [MASK_IN_W-1:0] mask;
		repeat (count) begin
			mask = MASK_IN_W'($urandom());
			pick_range(lpos, rpos);
			if ($urandom_range(0, 1) == 0)
				send_item(CMD_TOGGLE, lpos, rpos, mask);
			else
				send_item(CMD_QUERY, lpos, rpos, mask);
		end
		wait_drain();
	endtask

	// The receiver holds off while items keep coming back to back, so the
	// result register fills and the block has to stall its input.
	task automatic test_backpressure(input int unsigned count);
		logic [POS_W-1:0] lpos;
		logic [POS_W-1:0] rpos;
		tx_gaps = 1'b0;
		rx_hold_len = 300;
		repeat (count) begin
			pick_range(lpos, rpos);
			send_item($urandom_range(0, 1) ? CMD_QUERY : CMD_TOGGLE, lpos, rpos,
				MASK_IN_W'($urandom()));
		end
		tx_gaps = 1'b1;
		wait_drain();
	endtask

	// Toggles crowd a small window of leaves; queries cut across its borders.
	task automatic test_window(input int unsigned count);
		int unsigned          base;
		logic [POS_W-1:0]     lpos;
		logic [POS_W-1:0]     rpos;
		logic [MASK_IN_W-1:0] mask;
		base = $urandom_range(0, LEAVES - 16);
		repeat (count) begin
			if ($urandom_range(0, 19) == 0)
				base = $urandom_range(0, LEAVES - 16);
			mask = $urandom_range(0, 1) ? MASK_IN_W'(1) << $urandom_range(0, MASK_IN_W - 1)
				: MASK_IN_W'($urandom());
			if ($urandom_range(0, 2) == 0) begin
				lpos = POS_W'(base + $urandom_range(0, 15));
				send_item(CMD_TOGGLE, lpos, POS_W'($urandom()), mask);
			end else begin
				lpos = (base < 4) ? '0 : POS_W'(base - $urandom_range(0, 4));
				rpos = POS_W'(base + $urandom_range(0, 19));
				send_item(CMD_QUERY, lpos, rpos, mask);
			end
		end
		wait_drain();
	endtask

	task automatic test_full_rate(input int unsigned count);
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		test_random_mix(count);
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
	endtask

	initial begin : receiver
		int unsigned len;
		forever begin
			@(posedge clk);
			if (rx_hold_len != 0) begin
				m_tready <= 1'b0;
				len = rx_hold_len;
				rx_hold_len = 0;
				repeat (len) @(posedge clk);
			end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		logic [OUT_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (range_xor_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR: result 0x%07h with none expected", m_tdata[OUT_W-1:0]);
			end else begin
				want = range_xor_q.pop_front();
				if (want != 0)
					n_nonzero++;
				if (m_tdata[OUT_W-1:0] !== want) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("ERROR: range_xor expected 0x%07h, got 0x%07h",
							want, m_tdata[OUT_W-1:0]);
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("ERROR: timed out after %0d cycles", cycles);
		$display("FAILURE");
		$finish;
	end

	initial begin
		for (int i = 0; i < 2 * LEAVES; i++)
			tree_model[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(450);
		test_backpressure(30);
		test_window(300);
		test_full_rate(100);

		wait_drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (range_xor_q.size() != 0)
			errors++;

		$display("Ran %0d toggles and %0d range queries; %0d results, %0d of them nonzero.",
			n_toggles, n_queries, n_results, n_nonzero);
		$display("Longest input stall %0d cycles; %0d errors.", max_in_wait, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
